// File: rtl/core/assert_macros.svh
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is held.
`define MBPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition never holds on a rising edge outside reset.
`define MBPS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: rtl/core/mbps_pkg.sv
`default_nettype none

package mbps_pkg;

  // Coordinate width (Q16.16) and half-unit width (sum of two coordinates)
  localparam int CW = 32;
  localparam int HW = CW + 1;

  // Default number of steps per segment
  localparam int DEF_SEGMENT_STEPS = 16;

  // Command queue depth and pointer width
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // Register stages of the constant divider
  localparam int DIV_STAGES = 3;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [HW-1:0] half_t;

  // One waypoint's work: main segment (line or quad), optional tail line.
  // All points in half units (twice the coordinate).
  typedef struct packed {
    logic  quad;   // main segment is a quadratic curve
    logic  tail;   // append line from main end point to the waypoint
    half_t ma_x;   // main start
    half_t mc_x;   // main control
    half_t mb_x;   // main end, also tail start
    half_t tb_x;   // tail end
    half_t ma_y;
    half_t mc_y;
    half_t mb_y;
    half_t tb_y;
  } cmd_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAIN,
    ST_TAIL
  } seq_state_e;

  // Back end status seen by the top level
  typedef struct packed {
    logic idle;
    logic pop;
  } back_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/mbps_front.sv
`default_nettype none

module mbps_front import mbps_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  output logic        ready_o,
  input  wire coord_t wp_x_i,
  input  wire coord_t wp_y_i,
  input  wire logic   last_i,
  input  wire logic   q_ready_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  coord_t     older_x_q, older_y_q, newer_x_q, newer_y_q;
  logic [1:0] seen_q, seen_d;
  logic       accept;
  logic       quad;
  half_t      ox, oy, nx, ny, px, py;

  assign ready_o = q_ready_i;
  assign accept  = valid_i && q_ready_i;

  // Classify the waypoint: a full count of seen points gives a curve
  assign quad = seen_q inside {2'd2, 2'd3};

  // Build segment end and control points in half units
  always_comb begin
    ox = HW'(older_x_q);
    oy = HW'(older_y_q);
    nx = HW'(newer_x_q);
    ny = HW'(newer_y_q);
    px = HW'(wp_x_i);
    py = HW'(wp_y_i);
    cmd_o.quad = quad;
    cmd_o.tail = last_i;
    cmd_o.ma_x = quad ? (ox + nx) : (nx + nx);
    cmd_o.ma_y = quad ? (oy + ny) : (ny + ny);
    cmd_o.mc_x = nx + nx;
    cmd_o.mc_y = ny + ny;
    cmd_o.mb_x = nx + px;
    cmd_o.mb_y = ny + py;
    cmd_o.tb_x = px + px;
    cmd_o.tb_y = py + py;
  end

  // First waypoint of a path queues nothing
  assign push_o = accept && (seen_q != 2'd0);

  // Count waypoints of the current path, saturate at two, clear on last
  always_comb begin
    seen_d = seen_q;
    if (accept) begin
      if (last_i) begin
        seen_d = 2'd0;
      end else if (seen_q == 2'd0 || seen_q == 2'd1) begin
        seen_d = seen_q + 2'd1;
      end else begin
        seen_d = 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= 2'd0;
      older_x_q <= '0;
      older_y_q <= '0;
      newer_x_q <= '0;
      newer_y_q <= '0;
    end else begin
      seen_q <= seen_d;
      if (accept) begin
        older_x_q <= newer_x_q;
        older_y_q <= newer_y_q;
        newer_x_q <= wp_x_i;
        newer_y_q <= wp_y_i;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mbps_queue.sv
`default_nettype none

module mbps_queue import mbps_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      ready_o,
  output logic      valid_o,
  output cmd_t      cmd_o,
  input  wire logic pop_i
);

  cmd_t             mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAW:0]     cnt_q;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != (QAW+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (QAW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (QAW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mbps_div.sv
`default_nettype none

// Division by the constant 2*STEPS^2 as a multiply by its rounded-up reciprocal:
// partial products, then two partial sums, then the final sum and shift.
module mbps_div import mbps_pkg::*; #(
  parameter int SEGMENT_STEPS = DEF_SEGMENT_STEPS,
  localparam int Divisor = 2 * SEGMENT_STEPS * SEGMENT_STEPS,
  localparam int DW      = $clog2(Divisor + 1),
  localparam int MW      = CW + DW
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [MW-1:0] dividend_i,
  output logic [CW-1:0]      quot_o
);

  // Reciprocal scaled by 2^Shift, exact for every dividend below Divisor*2^CW
  localparam int          LW    = $clog2(Divisor);
  localparam int          Shift = CW + 2 * LW;
  localparam logic [63:0] Recip = ((64'd1 << Shift) + 64'(Divisor) - 64'd1) / 64'(Divisor);

  // Split points of dividend and reciprocal, product and full sum widths
  localparam int XH  = 22;
  localparam int MH  = 23;
  localparam int PPW = XH + MH;
  localparam int FW  = 2 * (XH + MH);

  localparam logic [MH-1:0] RecipLo = Recip[MH-1:0];
  localparam logic [MH-1:0] RecipHi = Recip[2*MH-1:MH];

  logic [XH-1:0]  x_lo, x_hi;
  logic [PPW-1:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic [FW-1:0]  part_a_q, part_b_q;
  logic [CW-1:0]  quot_q;

  assign x_lo = dividend_i[XH-1:0];
  assign x_hi = XH'(dividend_i >> XH);

  // Partial products, partial sums, then final sum with the scale dropped
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q  <= PPW'(x_lo) * PPW'(RecipLo);
      pp_lh_q  <= PPW'(x_lo) * PPW'(RecipHi);
      pp_hl_q  <= PPW'(x_hi) * PPW'(RecipLo);
      pp_hh_q  <= PPW'(x_hi) * PPW'(RecipHi);
      part_a_q <= FW'(pp_ll_q) + (FW'(pp_hl_q) << XH);
      part_b_q <= (FW'(pp_lh_q) << MH) + (FW'(pp_hh_q) << (XH + MH));
      quot_q   <= CW'((part_a_q + part_b_q) >> Shift);
    end
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

// File: rtl/core/mbps_back.sv
`default_nettype none

module mbps_back import mbps_pkg::*; #(
  parameter int SEGMENT_STEPS = DEF_SEGMENT_STEPS
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_valid_i,
  input  wire cmd_t    cmd_i,
  output logic         pop_o,
  output back_stat_t   stat_o,
  output logic         m_tvalid_o,
  input  wire logic    m_tready_i,
  output logic [2*CW-1:0] m_tdata_o,
  output logic         m_tlast_o
);

  localparam int S       = SEGMENT_STEPS;
  localparam int JW      = $clog2(S + 1);
  localparam int WW      = $clog2(S * S + 1);
  localparam int PW      = HW + WW + 1;
  localparam int Divisor = 2 * S * S;
  localparam int DW      = $clog2(Divisor + 1);
  localparam int MW      = CW + DW;
  localparam int SW      = MW + 4;
  localparam int NSTG    = 3 + DIV_STAGES;

  // Rounding half plus a bias that keeps the dividend non-negative
  localparam logic [MW-1:0] Bias = (MW'(S * S) << CW) | MW'(S * S);

  seq_state_e state_q, state_d;
  logic [JW-1:0] j_q, j_d;
  cmd_t          cmd_q;
  logic          en, seg_end, load, issue, sample_last, quad_seg;
  logic [JW-1:0] u;
  logic [WW-1:0] w0_d, w1_d, w2_d, w0_q, w1_q, w2_q;
  half_t         ax_d, cx_d, bx_d, ay_d, cy_d, by_d;
  half_t         ax_q, cx_q, bx_q, ay_q, cy_q, by_q;
  logic signed [PW-1:0] p0x_q, p1x_q, p2x_q, p0y_q, p1y_q, p2y_q;
  logic [MW-1:0] mx_q, my_q;
  logic [CW-1:0] qx, qy;
  logic [NSTG-1:0] vld_q, lst_q;

  // Whole sample pipeline moves when the output beat is free or taken
  assign en      = !vld_q[NSTG-1] || m_tready_i;
  assign seg_end = (j_q == JW'(S));

  // Next state of the segment sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) state_d = ST_MAIN;
      end
      ST_MAIN: begin
        if (en && seg_end) begin
          if (cmd_q.tail) begin
            state_d = ST_TAIL;
          end else if (q_valid_i) begin
            state_d = ST_MAIN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (en && seg_end) state_d = q_valid_i ? ST_MAIN : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: queue pop, sample index, weights and operands
  always_comb begin
    issue       = (state_q != ST_IDLE) && en;
    sample_last = seg_end && ((state_q == ST_TAIL) || !cmd_q.tail);
    load        = q_valid_i && ((state_q == ST_IDLE) || (en && sample_last));
    quad_seg    = (state_q == ST_MAIN) && cmd_q.quad;
    u           = JW'(S) - j_q;

    j_d = j_q;
    if (load) begin
      j_d = '0;
    end else if (issue) begin
      j_d = seg_end ? '0 : j_q + JW'(1);
    end

    if (quad_seg) begin
      w0_d = WW'(u) * WW'(u);
      w1_d = (WW'(u) * WW'(j_q)) << 1;
      w2_d = WW'(j_q) * WW'(j_q);
    end else begin
      w0_d = WW'(S) * WW'(u);
      w1_d = '0;
      w2_d = WW'(S) * WW'(j_q);
    end

    if (state_q == ST_TAIL) begin
      ax_d = cmd_q.mb_x;
      ay_d = cmd_q.mb_y;
      bx_d = cmd_q.tb_x;
      by_d = cmd_q.tb_y;
    end else begin
      ax_d = cmd_q.ma_x;
      ay_d = cmd_q.ma_y;
      bx_d = cmd_q.mb_x;
      by_d = cmd_q.mb_y;
    end
    cx_d = cmd_q.mc_x;
    cy_d = cmd_q.mc_y;
  end

  assign pop_o       = load;
  assign stat_o.idle = (state_q == ST_IDLE);
  assign stat_o.pop  = load;

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_i;
    end
  end

  // Valid chain through issue, product, sum and division stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], issue};
    end
  end

  // Sample datapath: operands, weighted products, biased sum
  always_ff @(posedge clk_i) begin
    if (en) begin
      lst_q <= {lst_q[NSTG-2:0], sample_last};
      w0_q  <= w0_d;
      w1_q  <= w1_d;
      w2_q  <= w2_d;
      ax_q  <= ax_d;
      cx_q  <= cx_d;
      bx_q  <= bx_d;
      ay_q  <= ay_d;
      cy_q  <= cy_d;
      by_q  <= by_d;
      p0x_q <= $signed(ax_q) * $signed({1'b0, w0_q});
      p1x_q <= $signed(cx_q) * $signed({1'b0, w1_q});
      p2x_q <= $signed(bx_q) * $signed({1'b0, w2_q});
      p0y_q <= $signed(ay_q) * $signed({1'b0, w0_q});
      p1y_q <= $signed(cy_q) * $signed({1'b0, w1_q});
      p2y_q <= $signed(by_q) * $signed({1'b0, w2_q});
      mx_q  <= MW'(SW'(p0x_q) + SW'(p1x_q) + SW'(p2x_q) + SW'(Bias));
      my_q  <= MW'(SW'(p0y_q) + SW'(p1y_q) + SW'(p2y_q) + SW'(Bias));
    end
  end

  // Round-to-nearest division, one lane per axis
  mbps_div #(
    .SEGMENT_STEPS (SEGMENT_STEPS)
  ) u_div_x (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (mx_q),
    .quot_o     (qx)
  );

  mbps_div #(
    .SEGMENT_STEPS (SEGMENT_STEPS)
  ) u_div_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (my_q),
    .quot_o     (qy)
  );

  // Remove the bias: flip the sign bit of the quotient
  assign m_tvalid_o = vld_q[NSTG-1];
  assign m_tlast_o  = lst_q[NSTG-1];
  assign m_tdata_o  = {~qy[CW-1], qy[CW-2:0], ~qx[CW-1], qx[CW-2:0]};

endmodule

`default_nettype wire

// File: rtl/core/midpoint_bezier_path_smoother.sv
// Midpoint Bezier path smoother. Waypoints (signed Q16.16) enter one beat at a
// time; tlast on the input marks the final waypoint of a path. The first
// waypoint of a path gives no samples, the second gives a line from the first
// point to the midpoint of the two, and each later one gives a quadratic curve
// shaped by the previous point between the neighboring midpoints; a final
// waypoint adds a line from the last midpoint to itself. Each segment yields
// SEGMENT_STEPS+1 samples, rounded to nearest with ties upward, and tlast on
// the output marks the last sample caused by a waypoint. The back end issues
// one sample per clock while it has a segment and the output is not stalled.
// A two-entry command queue lets the front end take the next waypoints while
// the back end is busy. The sample path has an operand stage, weight multiply,
// sum, and a three-stage multiply by the reciprocal of 2*SEGMENT_STEPS^2.
// SEGMENT_STEPS ranges from 1 to 45.
`include "assert_macros.svh"
`default_nettype none

module midpoint_bezier_path_smoother import mbps_pkg::*; #(
  parameter int SEGMENT_STEPS = DEF_SEGMENT_STEPS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [63:0]   s_axis_tdata,   // [31:0] wp_x, [63:32] wp_y
  input  wire logic          s_axis_tlast,   // final_waypoint
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [63:0]        m_axis_tdata,   // [31:0] pt_x, [63:32] pt_y
  output logic               m_axis_tlast    // final_sample
);

  logic       push, q_ready, q_valid, pop;
  cmd_t       push_cmd, head_cmd;
  back_stat_t back_stat;

  // Accept waypoints and build segment commands
  mbps_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .wp_x_i    (s_axis_tdata[CW-1:0]),
    .wp_y_i    (s_axis_tdata[2*CW-1:CW]),
    .last_i    (s_axis_tlast),
    .q_ready_i (q_ready),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // Decouple front and back
  mbps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  // Generate samples
  mbps_back #(
    .SEGMENT_STEPS (SEGMENT_STEPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .stat_o     (back_stat),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

  `MBPS_ASSERT(a_idle_takes_cmd, clk_i, rst_ni,
    (back_stat.idle && q_valid) |-> back_stat.pop, "idle back end left a queued command")
  `MBPS_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni,
    back_stat.pop && !q_valid, "back end popped an empty queue")
  `MBPS_ASSERT(a_full_means_busy, clk_i, rst_ni,
    !q_ready |-> !back_stat.idle, "queue full while back end idle")

endmodule

`default_nettype wire

// File: tb/tb_midpoint_bezier_path_smoother.sv
`default_nettype none

module tb_midpoint_bezier_path_smoother;
  import mbps_pkg::*;

  localparam int     SEGMENT_STEPS = DEF_SEGMENT_STEPS;
  localparam int     CYCLE_LIMIT   = 400000;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     DRAIN_CYCLES  = 60;
  localparam int     PHASE_ITEMS   = 30;
  localparam coord_t COORD_MAX     = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN     = 32'sh8000_0000;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } waypoint_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;  // [31:0] wp_x, [63:32] wp_y
  logic        s_axis_tlast  = 1'b0;  // final_waypoint
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;  // [31:0] pt_x, [63:32] pt_y
  logic        m_axis_tlast;  // final_sample

  // Waypoints waiting for the driver and samples waiting for the block
  waypoint_t pending_wps[$];
  sample_t   expected_samples[$];

  // Predictor copy of the smoother state
  coord_t      older_x = '0, older_y = '0, newer_x = '0, newer_y = '0;
  logic [1:0]  pts_seen = '0;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off_armed = 1'b0;
  int   held_cycles = 0;
  logic in_beat_taken = 1'b0;

  int   cycle_count = 0;
  int   wps_queued = 0;
  int   wps_accepted = 0;
  int   paths_queued = 0;
  int   lone_paths = 0;
  int   samples_checked = 0;
  int   input_stall_cycles = 0;
  int   errors = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  midpoint_bezier_path_smoother #(
    .SEGMENT_STEPS(SEGMENT_STEPS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Round num/den to nearest, ties toward plus infinity
  function automatic coord_t round_half_up(longint num, longint den);
    longint n, q;
    n = num + den / 2;
    q = n / den;
    if (n % den < 0) q = q - 1;
    return coord_t'(q);
  endfunction

  // Queue the samples of one segment; points are in half units
  function automatic void push_segment(bit curved, longint ax, longint ay, longint cx,
                                       longint cy, longint bx, longint by);
    longint  s, j, u, w0, w1, w2, den;
    sample_t smp;
    s   = SEGMENT_STEPS;
    den = curved ? 2 * s * s : 2 * s;
    for (j = 0; j <= s; j++) begin
      u = s - j;
      if (curved) begin
        w0 = u * u;
        w1 = 2 * u * j;
        w2 = j * j;
      end else begin
        w0 = u;
        w1 = 0;
        w2 = j;
      end
      smp.x    = round_half_up(w0 * ax + w1 * cx + w2 * bx, den);
      smp.y    = round_half_up(w0 * ay + w1 * cy + w2 * by, den);
      smp.last = 1'b0;
      expected_samples = {expected_samples, smp};
    end
  endfunction

  // Work out the samples one accepted waypoint causes and advance the state
  function automatic void predict_samples(waypoint_t wp);
    longint  px, py, nx, ny, ox, oy;
    int      first;
    sample_t tail;
    px    = longint'(wp.x);
    py    = longint'(wp.y);
    nx    = longint'(newer_x);
    ny    = longint'(newer_y);
    ox    = longint'(older_x);
    oy    = longint'(older_y);
    first = expected_samples.size();
    if (pts_seen == 2'd1) begin
      push_segment(1'b0, 2 * nx, 2 * ny, 0, 0, nx + px, ny + py);
    end else if (pts_seen != 2'd0) begin
      push_segment(1'b1, ox + nx, oy + ny, 2 * nx, 2 * ny, nx + px, ny + py);
    end
    if (wp.last && pts_seen != 2'd0) begin
      push_segment(1'b0, nx + px, ny + py, 0, 0, 2 * px, 2 * py);
    end
    // Mark the last sample of this waypoint
    if (expected_samples.size() > first) begin
      tail      = expected_samples[expected_samples.size() - 1];
      tail.last = 1'b1;
      expected_samples[expected_samples.size() - 1] = tail;
    end
    older_x = newer_x;
    older_y = newer_y;
    newer_x = wp.x;
    newer_y = wp.y;
    if (wp.last) pts_seen = 2'd0;
    else if (pts_seen == 2'd0) pts_seen = 2'd1;
    else pts_seen = 2'd2;
  endfunction

  // Offer waypoints at the falling edge; hold a beat until it is taken
  always @(negedge clk_i) begin : drive_waypoints
    waypoint_t next_wp;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_beat_taken) begin
      if (pending_wps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_wp = pending_wps.pop_front();
        s_axis_tdata  <= {next_wp.y, next_wp.x};
        s_axis_tlast  <= next_wp.last;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Drive the receiver ready; run the long hold-off once when armed
  always @(negedge clk_i) begin
    if (hold_off_armed && held_cycles < HOLD_CYCLES) begin
      held_cycles   <= held_cycles + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Take input beats into the predictor and check output beats
  always @(posedge clk_i) begin : check_samples
    waypoint_t wp;
    sample_t   got, want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d samples outstanding", $realtime,
               cycle_count, expected_samples.size());
      $display("simulation failed");
      $finish;
    end else begin
      in_beat_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        wp.x    = coord_t'(s_axis_tdata[31:0]);
        wp.y    = coord_t'(s_axis_tdata[63:32]);
        wp.last = s_axis_tlast;
        predict_samples(wp);
        wps_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.x    = coord_t'(m_axis_tdata[31:0]);
        got.y    = coord_t'(m_axis_tdata[63:32]);
        got.last = m_axis_tlast;
        if (expected_samples.size() == 0) begin
          errors++;
          $display("%0t: unexpected sample x=%h y=%h last=%b", $realtime, got.x, got.y,
                   got.last);
        end else begin
          want = expected_samples.pop_front();
          samples_checked++;
          if (got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
            errors++;
            $display("%0t: sample mismatch: expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
                     $realtime, want.x, want.y, want.last, got.x, got.y, got.last);
          end
        end
      end
    end
  end

  task automatic add_waypoint(coord_t x, coord_t y, bit last);
    waypoint_t wp;
    wp.x    = x;
    wp.y    = y;
    wp.last = last;
    pending_wps = {pending_wps, wp};
    wps_queued++;
    if (last) paths_queued++;
  endtask

  // Mostly full-range values, some small ones near zero, some extremes
  function automatic coord_t random_coord();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) return coord_t'($urandom);
    if (pick < 8) return coord_t'(int'($urandom_range(511)) - 256);
    case ($urandom_range(3))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      default: return -1;
    endcase
  endfunction

  // Queue one path; now and then a long one to keep the counter saturated
  task automatic add_random_path();
    int len, i;
    len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
    if (len == 1) lone_paths++;
    for (i = 0; i < len; i++) add_waypoint(random_coord(), random_coord(), i == len - 1);
  endtask

  // Wait until every queued waypoint is taken and every sample has come
  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (wps_accepted != wps_queued || expected_samples.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, bit long_hold);
    int start;
    @(posedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (long_hold) hold_off_armed = 1'b1;
    start = wps_queued;
    while (wps_queued - start < PHASE_ITEMS) add_random_path();
    wait_for_drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Lone waypoint: nothing comes out
    add_waypoint(32'sd100, -32'sd5, 1'b1);
    lone_paths++;
    // Two-point path at the extremes: line to the midpoint, then to the end
    add_waypoint(COORD_MAX, COORD_MIN, 1'b0);
    add_waypoint(COORD_MIN, COORD_MAX, 1'b1);
    // Small odd values hit rounding ties on both signs
    add_waypoint(32'sd0, 32'sd0, 1'b0);
    add_waypoint(32'sd1, -32'sd1, 1'b0);
    add_waypoint(-32'sd1, 32'sd1, 1'b0);
    add_waypoint(32'sd3, -32'sd3, 1'b1);
    // Curves swinging between the extremes
    add_waypoint(COORD_MAX, COORD_MAX, 1'b0);
    add_waypoint(COORD_MIN, COORD_MIN, 1'b0);
    add_waypoint(COORD_MAX, COORD_MAX, 1'b0);
    add_waypoint(COORD_MIN, COORD_MAX, 1'b1);
    // Longer path with the counter held at two
    add_waypoint(32'sd0, 32'sd0, 1'b0);
    add_waypoint(-32'sd1, -32'sd1, 1'b0);
    add_waypoint(32'sd1, 32'sd1, 1'b0);
    add_waypoint(32'sh1234_5678, -32'sh0123_4568, 1'b0);
    add_waypoint(COORD_MIN, 32'sd0, 1'b0);
    add_waypoint(32'sd0, COORD_MAX, 1'b0);
    add_waypoint(COORD_MAX, COORD_MIN, 1'b0);
    add_waypoint(-32'sh0001_8000, 32'sh0002_4000, 1'b1);
    // Lone waypoint right after a full path
    add_waypoint(COORD_MIN, COORD_MIN, 1'b1);
    lone_paths++;
    wait_for_drain();

    // Random paths under changing flow control
    run_phase(0, 0, 1'b0);
    run_phase(51, 0, 1'b0);
    run_phase(0, 51, 1'b0);
    run_phase(28, 28, 1'b0);
    run_phase(0, 0, 1'b1);

    $display("%0d waypoints in %0d paths (%0d lone), %0d samples checked, %0d mismatches",
             wps_accepted, paths_queued, lone_paths, samples_checked, errors);
    $display("input back-pressured for %0d cycles, receiver held off for %0d cycles",
             input_stall_cycles, held_cycles);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
